[design/xcrc_rx_pkg.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Shared types, protocol bytes and sequencing codes for the block receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcrc_rx_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES = 128;
  localparam int FRAME_WORDS = FRAME_BYTES / 2;
  localparam int WORD_W      = $clog2(FRAME_WORDS);

  // Protocol bytes.
  localparam logic [7:0] B_SOH  = 8'h01;
  localparam logic [7:0] B_EOT  = 8'h04;
  localparam logic [7:0] B_ACK  = 8'h06;
  localparam logic [7:0] B_NAK  = 8'h15;
  localparam logic [7:0] B_C    = 8'h43;
  localparam logic [7:0] B_D    = 8'h64;
  localparam logic [7:0] B_O    = 8'h4F;
  localparam logic [7:0] B_K    = 8'h4B;
  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_LF   = 8'h0A;

  // CRC-16 polynomial.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Receiver phases.
  localparam logic [2:0] PH_WAIT_D  = 3'd0;
  localparam logic [2:0] PH_SEND_C  = 3'd1;
  localparam logic [2:0] PH_FRAME   = 3'd2;
  localparam logic [2:0] PH_BETWEEN = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  // Positions of bytes within a frame (after SOH).
  localparam logic [7:0] IDX_BLOCK      = 8'd0;
  localparam logic [7:0] IDX_COMPL      = 8'd1;
  localparam logic [7:0] IDX_DATA_FIRST = 8'd2;
  localparam logic [7:0] IDX_DATA_LAST  = 8'(FRAME_BYTES + 1);
  localparam logic [7:0] IDX_CRC_HI     = 8'(FRAME_BYTES + 2);

  // Entries of the reply message table.
  localparam logic [2:0] MSG_C   = 3'd0;
  localparam logic [2:0] MSG_NAK = 3'd1;
  localparam logic [2:0] MSG_ACK = 3'd2;
  localparam logic [2:0] MSG_O   = 3'd3;
  localparam logic [2:0] MSG_K   = 3'd4;
  localparam logic [2:0] MSG_CR  = 3'd5;
  localparam logic [2:0] MSG_LF  = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TICKS   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  TICKS_RESET   = 8'd50;
  localparam logic [3:0]  TIMEOUT_RESET = 4'd3;
  localparam logic [15:0] LIMIT_RESET   = 16'h0C00;

  // One input transaction.
  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic       rx_error;
  } rx_item_t;

  // One result transaction.
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        write_valid;
    logic [15:0] write_address;
    logic [15:0] write_word;
    logic        page_first;
    logic        page_last;
    logic        run_app;
    logic        last;
  } result_t;

  // Commands to the CRC unit.
  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_ctl_t;

  // Byte sent for each reply message entry.
  function automatic logic [7:0] msg_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      MSG_C:   b = B_C;
      MSG_NAK: b = B_NAK;
      MSG_ACK: b = B_ACK;
      MSG_O:   b = B_O;
      MSG_K:   b = B_K;
      MSG_CR:  b = B_CR;
      MSG_LF:  b = B_LF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[design/xcrc_rx_crc.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC bit-serial CRC unit
// Folds one byte into the running CRC-16, one polynomial step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_rx_crc
  import xcrc_rx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire crc_ctl_t    ctl,
  output logic [15:0]      crc,
  output logic             busy
);

  logic [3:0] count;

  // The byte is XORed into the top half, then eight shift steps follow.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= 16'h0000;
      count <= 4'd0;
    end else if (ctl.clear) begin
      crc   <= 16'h0000;
      count <= 4'd0;
    end else if (ctl.start) begin
      crc   <= crc ^ {ctl.data, 8'h00};
      count <= 4'd8;
    end else if (count != 4'd0) begin
      if (crc[15]) begin
        crc <= {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc <= {crc[14:0], 1'b0};
      end
      count <= count - 4'd1;
    end
  end

  assign busy = (count != 4'd0);

endmodule

`default_nettype wire

[design/xmodem_crc_block_receiver.sv]
// A tick or control byte is decoded in S_IDLE; a frame data byte then waits in S_CRC
// until the bit-serial CRC unit (one polynomial step per cycle) is done with it.
// Replies stream one result per cycle while out_stall is low; a stored frame emits
// 64 flash words, each through S_READ for the registered buffer read, then S_WRITE.
// Reset is synchronous and active high; the frame buffer is not cleared.
// ----------------------------------------------------------------------------
// XMODEM-CRC block receiver
// Bootloader receive side: handshake, frame reception, checks and flash output.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_crc_block_receiver
  import xcrc_rx_pkg::*;
#(
  parameter int PAGE_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire rx_item_t    in_data,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output result_t          out_data,
  // Configuration channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int PW = $clog2(PAGE_BYTES + 2);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CRC   = 3'd1;
  localparam logic [2:0] S_MSG   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]        state;
  logic [2:0]        phase;
  logic [7:0]        tick_count;
  logic [3:0]        seconds_waited;
  logic [7:0]        expected_block;
  logic              header_good;
  logic [7:0]        byte_index;
  logic [7:0]        received_hi;
  logic [15:0]       flash_address;
  logic [7:0]        ticks_per_second;
  logic [3:0]        startup_timeout_seconds;
  logic [15:0]       flash_limit;
  logic [2:0]        msg_idx;
  logic [2:0]        msg_end;
  logic [WORD_W-1:0] word_idx;
  logic [PW-1:0]     page_off;

  // Frame buffer split into even and odd bytes so a word reads in one access.
  logic [7:0]        buf_even [FRAME_WORDS];
  logic [7:0]        buf_odd  [FRAME_WORDS];
  logic [7:0]        rd_even;
  logic [7:0]        rd_odd;

  crc_ctl_t          crc_ctl;
  logic [15:0]       crc_value;
  logic              crc_busy;

  logic              accept;
  logic              byte_ok;
  logic [6:0]        data_off;
  logic              is_data;
  logic              can_load;
  logic              out_load;
  logic [7:0]        tick_next;
  logic              second;
  logic [4:0]        seconds_next;
  logic              frame_good;
  logic              word_final;
  logic [PW-1:0]     page_off_step;
  logic [15:0]       word_address;
  result_t           msg_result;
  result_t           word_result;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign can_load  = !out_valid || !out_stall;
  assign out_load  = ((state == S_MSG) || (state == S_WRITE)) && can_load;

  assign byte_ok   = !in_data.operation && !in_data.rx_error;
  assign is_data   = byte_index inside {[IDX_DATA_FIRST:IDX_DATA_LAST]};
  assign data_off  = 7'(byte_index - IDX_DATA_FIRST);

  assign tick_next    = tick_count + 8'd1;
  assign second       = (tick_next >= ticks_per_second);
  assign seconds_next = {1'b0, seconds_waited} + 5'd1;
  assign frame_good   = header_good && (crc_value == {received_hi, in_data.rx_byte});

  assign word_final    = (word_idx == WORD_W'(FRAME_WORDS - 1));
  assign page_off_step = page_off + PW'(2);
  assign word_address  = flash_address + {{(15 - WORD_W){1'b0}}, word_idx, 1'b0};

  // Commands for the CRC unit, decoded from the accepted transaction.
  always_comb begin
    crc_ctl.clear = accept && byte_ok && in_data.rx_byte == B_SOH &&
                    (phase == PH_SEND_C || phase == PH_BETWEEN);
    crc_ctl.start = accept && byte_ok && phase == PH_FRAME && is_data;
    crc_ctl.data  = in_data.rx_byte;
  end

  xcrc_rx_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .crc  (crc_value),
    .busy (crc_busy)
  );

  // Reply byte from the message table.
  always_comb begin
    msg_result          = '0;
    msg_result.tx_valid = 1'b1;
    msg_result.tx_byte  = msg_byte(msg_idx);
    msg_result.run_app  = (msg_idx == MSG_LF);
    msg_result.last     = (msg_idx == msg_end);
  end

  // Flash word at the current read position; the ACK rides on the final one.
  always_comb begin
    word_result               = '0;
    word_result.tx_valid      = word_final;
    word_result.tx_byte       = word_final ? B_ACK : 8'h00;
    word_result.write_valid   = 1'b1;
    word_result.write_address = word_address;
    word_result.write_word    = {rd_odd, rd_even};
    word_result.page_first    = (page_off == '0);
    word_result.page_last     = word_final || (page_off_step == PW'(PAGE_BYTES));
    word_result.run_app       = 1'b0;
    word_result.last          = word_final;
  end

  // Frame buffer write on data bytes, registered read at the current word.
  always_ff @(posedge clk) begin
    if (crc_ctl.start) begin
      if (data_off[0]) begin
        buf_odd[data_off[6:1]] <= in_data.rx_byte;
      end else begin
        buf_even[data_off[6:1]] <= in_data.rx_byte;
      end
    end
    rd_even <= buf_even[word_idx];
    rd_odd  <= buf_odd[word_idx];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second        <= TICKS_RESET;
      startup_timeout_seconds <= TIMEOUT_RESET;
      flash_limit             <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TICKS:   ticks_per_second        <= cfg_data[7:0];
        CFG_TIMEOUT: startup_timeout_seconds <= cfg_data[3:0];
        CFG_LIMIT:   flash_limit             <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Protocol state, sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_WAIT_D;
      tick_count     <= 8'd0;
      seconds_waited <= 4'd0;
      expected_block <= 8'd1;
      header_good    <= 1'b0;
      byte_index     <= 8'd0;
      received_hi    <= 8'd0;
      flash_address  <= 16'd0;
      msg_idx        <= MSG_C;
      msg_end        <= MSG_C;
      word_idx       <= '0;
      page_off       <= '0;
      out_valid      <= 1'b0;
    end else begin
      // The result register loads a new transaction or empties once taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        // Decode one accepted transaction.
        S_IDLE: begin
          if (accept && phase <= PH_BETWEEN) begin
            if (in_data.operation) begin
              tick_count <= second ? 8'd0 : tick_next;
              if (second && phase == PH_WAIT_D) begin
                if (seconds_next >= {1'b0, startup_timeout_seconds}) begin
                  seconds_waited <= 4'd0;
                  phase          <= PH_DONE;
                  msg_idx        <= MSG_O;
                  msg_end        <= MSG_LF;
                  state          <= S_MSG;
                end else begin
                  seconds_waited <= seconds_next[3:0];
                end
              end else if (second && phase == PH_SEND_C) begin
                msg_idx <= MSG_C;
                msg_end <= MSG_C;
                state   <= S_MSG;
              end
            end else if (!in_data.rx_error) begin
              case (phase)
                PH_WAIT_D: begin
                  if (in_data.rx_byte == B_D) begin
                    phase <= PH_SEND_C;
                  end
                end
                PH_FRAME: begin
                  byte_index <= (byte_index > IDX_CRC_HI) ? 8'd0 : byte_index + 8'd1;
                  if (byte_index == IDX_BLOCK) begin
                    header_good <= (in_data.rx_byte == expected_block);
                  end else if (byte_index == IDX_COMPL) begin
                    header_good <= header_good && (in_data.rx_byte == ~expected_block);
                  end else if (is_data) begin
                    state <= S_CRC;
                  end else if (byte_index == IDX_CRC_HI) begin
                    received_hi <= in_data.rx_byte;
                  end else begin
                    // Last CRC byte: check the frame and answer it.
                    phase <= PH_BETWEEN;
                    if (!frame_good) begin
                      msg_idx <= MSG_NAK;
                      msg_end <= MSG_NAK;
                      state   <= S_MSG;
                    end else begin
                      expected_block <= expected_block + 8'd1;
                      if (flash_address < flash_limit) begin
                        word_idx <= '0;
                        page_off <= '0;
                        state    <= S_READ;
                      end else begin
                        msg_idx <= MSG_ACK;
                        msg_end <= MSG_ACK;
                        state   <= S_MSG;
                      end
                    end
                  end
                end
                default: begin
                  // Waiting for the first frame or between frames.
                  if (in_data.rx_byte == B_SOH) begin
                    phase       <= PH_FRAME;
                    byte_index  <= 8'd0;
                    header_good <= 1'b0;
                    received_hi <= 8'd0;
                  end else if (in_data.rx_byte == B_EOT && phase == PH_BETWEEN) begin
                    phase   <= PH_DONE;
                    msg_idx <= MSG_ACK;
                    msg_end <= MSG_LF;
                    state   <= S_MSG;
                  end
                end
              endcase
            end
          end
        end

        // Wait for the CRC unit to fold in the data byte.
        S_CRC: begin
          if (!crc_busy) begin
            state <= S_IDLE;
          end
        end

        // Stream reply bytes from the message table.
        S_MSG: begin
          if (can_load) begin
            out_data <= msg_result;
            if (msg_idx == msg_end) begin
              state <= S_IDLE;
            end else begin
              msg_idx <= msg_idx + 3'd1;
            end
          end
        end

        // Wait for the registered frame buffer read.
        S_READ: begin
          state <= S_WRITE;
        end

        // Emit one flash word.
        S_WRITE: begin
          if (can_load) begin
            out_data <= word_result;
            if (page_off_step >= PW'(PAGE_BYTES)) begin
              page_off <= page_off_step - PW'(PAGE_BYTES);
            end else begin
              page_off <= page_off_step;
            end
            if (word_final) begin
              flash_address <= flash_address + 16'(FRAME_BYTES);
              state         <= S_IDLE;
            end else begin
              word_idx <= word_idx + WORD_W'(1);
              state    <= S_READ;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
